// ===== hw/rtl/ols_pkg.sv =====
`default_nettype none
package ols_pkg;

    // Default geometry of the line store and the tab grid.
    localparam int LINE_LEN_DEF = 64;
    localparam int TAB_STOP_DEF = 8;

    localparam int BYTE_W = 8;

    // Byte codes that the renderer treats specially.
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_BEL   = 8'h07;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SUB   = 8'h1A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_TEST,
        S_BYTE,
        S_DONE
    } t_state;

    // Control strobes toward the line store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clr;
    } t_store_ctl;

endpackage
`default_nettype wire

// ===== hw/rtl/overstrike_line_renderer.sv =====
`default_nettype none
// Channel   Dir  Signals                           Contents
// s_axis    in   tvalid, tready, tdata[7:0]        in_byte
// m_axis    out  tvalid, tready, tdata[7:0],       out_byte
//                tlast, tuser[0]                   last, status
//
// Cursor bytes, bell, Ctrl-Z and ordinary bytes are handled in the idle state.
// A line feed emits each line byte through a store read, a test and a
// hand-off, then sends the closing newline; the output side can stall
// any hand-off by holding tready low.
// An overflow result is loaded while idle and sent from the closing state.
// The single shared adder and the one-read-per-cycle line store shape this sequence.
// Reset empties the store at once through per-entry valid bits; no clearing pass.
// The input is not ready while a line is being emitted or a result waits.
module overstrike_line_renderer #(
    parameter int LINE_LEN = ols_pkg::LINE_LEN_DEF,
    parameter int TAB_STOP = ols_pkg::TAB_STOP_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic [0:0] m_axis_tuser    // [0] status
);

    localparam int IW = $clog2(LINE_LEN);
    localparam int PW = (TAB_STOP > 2) ? $clog2(TAB_STOP) : 1;
    localparam int TW = $clog2(TAB_STOP + 1);
    // Width of the shared adder: wide enough for column plus tab step.
    localparam int SW = ((IW > TW) ? IW : TW) + 1;
    localparam logic [IW-1:0] COL_MAX = IW'(LINE_LEN - 1);
    // Tab phase of the last column, where the column saturates.
    localparam logic [PW-1:0] PH_END  = PW'((LINE_LEN - 1) % TAB_STOP);
    localparam logic [PW-1:0] PH_TOP  = PW'(TAB_STOP - 1);

    ols_pkg::t_state r_state, n_state;

    logic [IW-1:0] r_col, n_col;
    logic [PW-1:0] r_phase, n_phase;     // column modulo the tab stop
    logic [IW-1:0] r_hi, n_hi;           // one past the highest written entry
    logic [IW-1:0] r_idx, n_idx;         // scan position while emitting
    logic          r_halt, n_halt;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;
    logic          r_out_status, n_out_status;

    logic          w_in_acc;
    logic          w_live;
    logic          w_is_write;
    logic [SW-1:0] w_add_a;
    logic [SW-1:0] w_add_b;
    logic [SW-1:0] w_sum;
    logic          w_ovr;
    logic [IW-1:0] w_sat;
    logic [PW-1:0] w_ph_inc;
    logic [7:0]    w_rd_data;
    ols_pkg::t_store_ctl w_ctl;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_live   = w_in_acc && !r_halt;

    // Every byte other than space and the handled control bytes overwrites the store at the cursor.
    always_comb begin
        unique case (s_axis_tdata)
            ols_pkg::CH_SUB, ols_pkg::CH_CR, ols_pkg::CH_LF, ols_pkg::CH_SPACE,
            ols_pkg::CH_BEL, ols_pkg::CH_TAB, ols_pkg::CH_BS: w_is_write = 1'b0;
            default: w_is_write = 1'b1;
        endcase
    end

    // The one shared adder: it moves the cursor while idle and steps the
    // scan index while a line goes out. Backspace adds all ones, i.e. -1.
    always_comb begin
        w_add_a = SW'(r_col);
        w_add_b = SW'(1);
        if (r_state == ols_pkg::S_BYTE) begin
            w_add_a = SW'(r_idx);
        end else if (s_axis_tdata == ols_pkg::CH_TAB) begin
            w_add_b = SW'(TAB_STOP) - SW'(r_phase);
        end else if (s_axis_tdata == ols_pkg::CH_BS) begin
            w_add_b = '1;
        end
    end

    assign w_sum    = w_add_a + w_add_b;
    assign w_ovr    = w_sum > SW'(LINE_LEN - 1);
    assign w_sat    = w_ovr ? COL_MAX : w_sum[IW-1:0];
    assign w_ph_inc = w_ovr ? PH_END : ((r_phase == PH_TOP) ? '0 : r_phase + PW'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ols_pkg::S_IDLE: begin
                if (w_live && s_axis_tdata == ols_pkg::CH_LF) begin
                    n_state = (r_hi == '0) ? ols_pkg::S_DONE : ols_pkg::S_READ;
                end else if (w_live && w_is_write && w_sat == COL_MAX) begin
                    n_state = ols_pkg::S_DONE;
                end
            end
            ols_pkg::S_READ: n_state = ols_pkg::S_TEST;
            ols_pkg::S_TEST: begin
                n_state = (w_rd_data == ols_pkg::CH_NUL) ? ols_pkg::S_DONE
                                                         : ols_pkg::S_BYTE;
            end
            ols_pkg::S_BYTE: begin
                if (m_axis_tready) begin
                    n_state = (w_sum == SW'(r_hi)) ? ols_pkg::S_DONE
                                                   : ols_pkg::S_READ;
                end
            end
            ols_pkg::S_DONE: begin
                if (m_axis_tready) begin
                    n_state = ols_pkg::S_IDLE;
                end
            end
            default: n_state = ols_pkg::S_IDLE;
        endcase
    end

    // Datapath updates and result loading.
    always_comb begin
        n_col        = r_col;
        n_phase      = r_phase;
        n_hi         = r_hi;
        n_idx        = r_idx;
        n_halt       = r_halt;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        unique case (r_state)
            ols_pkg::S_IDLE: begin
                if (w_live) begin
                    unique case (s_axis_tdata)
                        ols_pkg::CH_SUB: n_halt = 1'b1;
                        ols_pkg::CH_CR: begin
                            n_col   = '0;
                            n_phase = '0;
                        end
                        ols_pkg::CH_LF: begin
                            n_idx        = '0;
                            n_out_byte   = ols_pkg::CH_LF;
                            n_out_last   = 1'b1;
                            n_out_status = 1'b0;
                        end
                        ols_pkg::CH_SPACE: begin
                            n_col   = w_sat;
                            n_phase = w_ph_inc;
                        end
                        ols_pkg::CH_BEL: n_halt = r_halt;
                        ols_pkg::CH_TAB: begin
                            n_col   = w_sat;
                            n_phase = w_ovr ? PH_END : '0;
                        end
                        ols_pkg::CH_BS: begin
                            if (r_col != '0) begin
                                n_col   = w_sum[IW-1:0];
                                n_phase = (r_phase == '0) ? PH_TOP : r_phase - PW'(1);
                            end
                        end
                        default: begin
                            n_col   = w_sat;
                            n_phase = w_ph_inc;
                            n_hi    = (w_sat > r_hi) ? w_sat : r_hi;
                            // Reaching the last column means the store overflowed.
                            if (w_sat == COL_MAX) begin
                                n_halt       = 1'b1;
                                n_out_byte   = ols_pkg::CH_NUL;
                                n_out_last   = 1'b1;
                                n_out_status = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ols_pkg::S_READ: n_idx = r_idx;
            ols_pkg::S_TEST: begin
                // A zero byte cuts the line short.
                n_out_byte   = (w_rd_data == ols_pkg::CH_NUL) ? ols_pkg::CH_LF : w_rd_data;
                n_out_last   = (w_rd_data == ols_pkg::CH_NUL);
                n_out_status = 1'b0;
            end
            ols_pkg::S_BYTE: begin
                if (m_axis_tready) begin
                    n_idx        = w_sum[IW-1:0];
                    n_out_byte   = ols_pkg::CH_LF;
                    n_out_last   = 1'b1;
                    n_out_status = 1'b0;
                end
            end
            ols_pkg::S_DONE: n_hi = '0;
            default: n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ols_pkg::S_IDLE;
            r_col   <= '0;
            r_phase <= '0;
            r_hi    <= '0;
            r_halt  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_phase <= n_phase;
            r_hi    <= n_hi;
            r_halt  <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    // The store is cleared while the closing item of a line waits; after an
    // overflow the block is halted, so clearing there changes nothing seen.
    assign w_ctl.wr_en = w_live && (r_state == ols_pkg::S_IDLE) && w_is_write;
    assign w_ctl.rd_en = (r_state == ols_pkg::S_READ);
    assign w_ctl.clr   = (r_state == ols_pkg::S_DONE);

    ols_line_store #(
        .LINE_LEN (LINE_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_wr_addr (r_col),
        .i_wr_data (s_axis_tdata),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    assign s_axis_tready   = (r_state == ols_pkg::S_IDLE);
    assign m_axis_tvalid   = (r_state == ols_pkg::S_BYTE) || (r_state == ols_pkg::S_DONE);
    assign m_axis_tdata    = r_out_byte;
    assign m_axis_tlast    = r_out_last;
    assign m_axis_tuser[0] = r_out_status;

endmodule
`default_nettype wire

// ===== hw/rtl/ols_line_store.sv =====
`default_nettype none
module ols_line_store #(
    parameter int LINE_LEN = ols_pkg::LINE_LEN_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire ols_pkg::t_store_ctl             i_ctl,
    input  wire [$clog2(LINE_LEN)-1:0]           i_wr_addr,
    input  wire [ols_pkg::BYTE_W-1:0]            i_wr_data,
    input  wire [$clog2(LINE_LEN)-1:0]           i_rd_addr,
    output logic [ols_pkg::BYTE_W-1:0]           o_rd_data
);

    logic [ols_pkg::BYTE_W-1:0] r_mem [LINE_LEN];
    logic [LINE_LEN-1:0]        r_vld;
    logic [ols_pkg::BYTE_W-1:0] r_rd_data;
    logic                       r_rd_vld;

    // An entry that has not been written since the last clear reads as a space.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_vld <= '0;
            end else if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : ols_pkg::CH_SPACE;

endmodule
`default_nettype wire
